// ----- hdl/reminder_alarm_table_defines.svh -----
// Assertion macros for the reminder alarm table.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef REMINDER_ALARM_TABLE_DEFINES_SVH
`define REMINDER_ALARM_TABLE_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define RAT_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition this cycle implies a consequence in the next cycle
`define RAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rat_pkg.sv -----
// Shared types and constants for the reminder alarm table.
// No dependencies; used by the interfaces, the slot store and the top level.
package rat_pkg;

  localparam int unsigned TIME_W       = 32;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned WIN_W        = 8;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned OUT_IDX_W    = 3;
  localparam int unsigned OUT_CNT_W    = 4;
  localparam int unsigned SLOT_COUNT_DEF = 8;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd30;

  // Command codes of an input beat
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_INSERT_DONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN_DONE   = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [TIME_W-1:0] reminder_time;
    logic [TAG_W-1:0]  reminder_tag;
    logic [TIME_W-1:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    result_kind;
    logic [OUT_IDX_W-1:0] slot_index;
    logic [TAG_W-1:0]     fired_tag;
    logic                 overwrote;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 last;
  } out_item_t;

  // One slot of the table
  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [TAG_W-1:0]  tag;
  } slot_entry_t;

  // Strobes from the sequencer to the slot store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } store_ctl_t;

endpackage

// ----- hdl/rat_in_if.sv -----
// Input channel of the reminder alarm table: valid/ready plus one input item.
// Depends on rat_pkg.
interface rat_in_if;
  logic               valid;
  logic               ready;
  rat_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/rat_out_if.sv -----
// Result channel of the reminder alarm table: valid/ready plus one result item.
// Depends on rat_pkg.
interface rat_out_if;
  logic               valid;
  logic               ready;
  rat_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/rat_slot_store.sv -----
// Slot store: due time and tag memory plus one occupancy bit per slot.
// Depends on rat_pkg. One read port (registered), one write port, one clear port.
module rat_slot_store #(
  parameter int unsigned SLOT_COUNT = rat_pkg::SLOT_COUNT_DEF,
  parameter int unsigned IDX_W      = $clog2(SLOT_COUNT)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rat_pkg::store_ctl_t  ctl_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  rat_pkg::slot_entry_t wr_entry_i,
  input  logic [IDX_W-1:0]     clr_addr_i,
  output logic                 rd_valid_o,
  output rat_pkg::slot_entry_t rd_entry_o
);
  import rat_pkg::*;

  slot_entry_t           mem_q [SLOT_COUNT];
  slot_entry_t           rd_entry_q;
  logic [SLOT_COUNT-1:0] occ_q;
  logic                  rd_valid_q;

  // Occupancy bits: a write sets, a clear drops; reset frees every slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        occ_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.clr_en) begin
        occ_q[clr_addr_i] <= 1'b0;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= occ_q[rd_addr_i];
      end
    end
  end

  // Entry memory, read data registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (ctl_i.rd_en) begin
      rd_entry_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_entry_o = rd_entry_q;

endmodule

// ----- hdl/reminder_alarm_table.sv -----
// Reminder alarm table: a table of reminder slots walked by a small sequencer.
// Channels: in_i (cmd, reminder_time, reminder_tag, current_time) and out_o
// (result_kind, slot_index, fired_tag, overwrote, entry_count, last), both
// valid/ready; a beat moves on a clock edge with valid and ready high.
// cfg_we_i/cfg_wdata_i write window_seconds (reset 30); write only when idle.
// An insert beat with a nonzero time stores into the lowest free slot, or
// over the earliest due time when the table is full; every insert returns one
// result. A tick beat walks all slots, drops expired ones silently, returns
// one beat per fired slot and a final scan-done beat with last set.
// The slot memory has one registered read port, so the walk reads one slot at
// a time: ST_RD issues the first read, and ST_EV judges a slot and reads the
// next one. in_i is ready only while no beat is in work. Results sit in an
// output register; while out_o is stalled the walk holds at the next fired
// slot or at the final beat, and no new beat is taken until the item
// finishes. Reset frees all slots, clears the count and the output valid,
// and loads the window with 30.
`include "reminder_alarm_table_defines.svh"

module reminder_alarm_table #(
  parameter int unsigned SLOT_COUNT = rat_pkg::SLOT_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rat_in_if.sink                     in_i,
  rat_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [rat_pkg::WIN_W-1:0]  cfg_wdata_i
);
  import rat_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_EV   = 5'b00100,
    ST_WR   = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic              cmd_q, cmd_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [TIME_W:0]   lo_q, lo_d;     // now - window, bit TIME_W is the borrow
  logic [TIME_W:0]   hi_q, hi_d;     // now + window
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  tgt_q, tgt_d;
  logic [TIME_W-1:0] min_q, min_d;
  logic              ow_q, ow_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [WIN_W-1:0]  window_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  store_ctl_t        ctl;
  logic [IDX_W-1:0]  rd_addr;
  slot_entry_t       wr_entry;
  logic              rd_valid;
  slot_entry_t       rd_entry;

  logic              out_free;
  logic              last_slot;
  logic              full;
  logic              under;
  logic              expire;
  logic              fire;
  logic [CNT_W-1:0]  count_dec;
  logic [CNT_W-1:0]  count_inc;

  rat_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (tgt_q),
    .wr_entry_i (wr_entry),
    .clr_addr_i (ptr_q),
    .rd_valid_o (rd_valid),
    .rd_entry_o (rd_entry)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign out_free  = !out_valid_q || out_o.ready;
  assign last_slot = (ptr_q == IDX_W'(SLOT_COUNT - 1));
  assign full      = (count_q == CNT_W'(SLOT_COUNT));
  assign count_dec = count_q - CNT_W'(1);
  assign count_inc = count_q + CNT_W'(1);
  assign wr_entry  = '{due: time_q, tag: tag_q};

  // Shared window compare unit, against bounds set up at accept time
  assign under  = lo_q[TIME_W];
  assign expire = !under && (rd_entry.due < lo_q[TIME_W-1:0]);
  assign fire   = ({1'b0, rd_entry.due} < hi_q) &&
                  (under || (rd_entry.due > lo_q[TIME_W-1:0]));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    time_d      = time_q;
    tag_d       = tag_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ptr_d       = ptr_q;
    tgt_d       = tgt_q;
    min_d       = min_q;
    ow_d        = ow_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    ctl         = '0;
    rd_addr     = ptr_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d  = in_i.data.cmd;
          time_d = in_i.data.reminder_time;
          tag_d  = in_i.data.reminder_tag;
          lo_d   = {1'b0, in_i.data.current_time} - (TIME_W+1)'(window_q);
          hi_d   = {1'b0, in_i.data.current_time} + (TIME_W+1)'(window_q);
          ptr_d  = '0;
          tgt_d  = '0;
          ow_d   = 1'b0;
          if (in_i.data.cmd == CMD_INSERT && in_i.data.reminder_time == '0) begin
            state_d = ST_WR;
          end else begin
            state_d = ST_RD;
          end
        end
      end

      ST_RD: begin
        ctl.rd_en = 1'b1;
        state_d   = ST_EV;
      end

      ST_EV: begin
        if (cmd_q == CMD_INSERT) begin
          if (!full) begin
            // first free slot wins
            if (!rd_valid) begin
              tgt_d   = ptr_q;
              state_d = ST_WR;
            end else if (last_slot) begin
              state_d = ST_WR;
            end else begin
              ctl.rd_en = 1'b1;
              rd_addr   = ptr_q + IDX_W'(1);
              ptr_d     = ptr_q + IDX_W'(1);
            end
          end else begin
            // earliest due time, ties to the lowest slot
            if (ptr_q == '0 || rd_entry.due < min_q) begin
              min_d = rd_entry.due;
              tgt_d = ptr_q;
            end
            if (last_slot) begin
              ow_d    = 1'b1;
              state_d = ST_WR;
            end else begin
              ctl.rd_en = 1'b1;
              rd_addr   = ptr_q + IDX_W'(1);
              ptr_d     = ptr_q + IDX_W'(1);
            end
          end
        end else begin
          if (!(rd_valid && !expire && fire) || out_free) begin
            if (rd_valid && (expire || fire)) begin
              ctl.clr_en = 1'b1;
              count_d    = count_dec;
            end
            if (rd_valid && !expire && fire) begin
              out_valid_d = 1'b1;
              out_d       = '{result_kind: KIND_FIRED,
                              slot_index:  OUT_IDX_W'(ptr_q),
                              fired_tag:   rd_entry.tag,
                              overwrote:   1'b0,
                              entry_count: OUT_CNT_W'(count_dec),
                              last:        1'b0};
            end
            if (last_slot) begin
              state_d = ST_FIN;
            end else begin
              ctl.rd_en = 1'b1;
              rd_addr   = ptr_q + IDX_W'(1);
              ptr_d     = ptr_q + IDX_W'(1);
            end
          end
        end
      end

      ST_WR: begin
        if (out_free) begin
          if (time_q != '0) begin
            ctl.wr_en = 1'b1;
            if (!ow_q) begin
              count_d = count_inc;
            end
          end
          out_valid_d = 1'b1;
          out_d       = '{result_kind: KIND_INSERT_DONE,
                          slot_index:  OUT_IDX_W'(tgt_q),
                          fired_tag:   tag_q,
                          overwrote:   ow_q,
                          entry_count: OUT_CNT_W'((time_q != '0 && !ow_q) ?
                                                  count_inc : count_q),
                          last:        1'b1};
          state_d     = ST_IDLE;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{result_kind: KIND_SCAN_DONE,
                          slot_index:  '0,
                          fired_tag:   '0,
                          overwrote:   1'b0,
                          entry_count: OUT_CNT_W'(count_q),
                          last:        1'b1};
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      window_q    <= WINDOW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    time_q <= time_d;
    tag_q  <= tag_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    ptr_q  <= ptr_d;
    tgt_q  <= tgt_d;
    min_q  <= min_d;
    ow_q   <= ow_d;
    out_q  <= out_d;
  end

  // Checks
  `RAT_ASSERT_HOLDS(a_count_bound, count_q <= CNT_W'(SLOT_COUNT), "slot count above table size")
  `RAT_ASSERT_NEXT(a_accept_busy, in_i.valid && in_i.ready, state_q != ST_IDLE, "accepted beat left sequencer idle")
  `RAT_ASSERT_HOLDS(a_ptr_range, ptr_q <= IDX_W'(SLOT_COUNT - 1) || state_q == ST_IDLE, "slot pointer out of range")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for reminder_alarm_table: directed and random insert/tick
// traffic with a scoreboard that predicts every result beat.
// Depends on rat_pkg, rat_in_if, rat_out_if and the reminder_alarm_table RTL.
`timescale 1ns / 1ps

module tb;
  import rat_pkg::*;

  localparam int unsigned SLOTS     = SLOT_COUNT_DEF;
  localparam int unsigned MAX_SHOWN = 10;

  // Slot table prediction plus the queue of result beats still owed
  class alarm_scoreboard;
    logic [TIME_W-1:0] due_time [SLOTS];
    logic [TAG_W-1:0]  slot_tag [SLOTS];
    int unsigned       occupied;
    logic [WIN_W-1:0]  window;
    out_item_t         pending_results[$];
    int unsigned       err_count, result_count;
    int unsigned       insert_count, tick_count, fired_count, overwrite_count;

    function new();
      foreach (due_time[i]) begin
        due_time[i] = '0;
        slot_tag[i] = '0;
      end
      occupied        = 0;
      window          = WINDOW_RESET;
      err_count       = 0;
      result_count    = 0;
      insert_count    = 0;
      tick_count      = 0;
      fired_count     = 0;
      overwrite_count = 0;
    endfunction

    function void set_window(logic [WIN_W-1:0] w);
      window = w;
    endfunction

    function void queue_result(logic [KIND_W-1:0] kind, logic [OUT_IDX_W-1:0] idx,
                               logic [TAG_W-1:0] tag, logic ow, logic fin);
      out_item_t r;
      r.result_kind = kind;
      r.slot_index  = idx;
      r.fired_tag   = tag;
      r.overwrote   = ow;
      r.entry_count = OUT_CNT_W'(occupied);
      r.last        = fin;
      pending_results.push_back(r);
    endfunction

    function void free_slot(int unsigned i);
      due_time[i] = '0;
      slot_tag[i] = '0;
      if (occupied > 0) occupied--;
    endfunction

    // Update the table for one accepted beat and queue the results it owes
    function void note_input(in_item_t it);
      int                target;
      logic              ow;
      logic [TIME_W:0]   due_w, now_w, win_w;
      logic [TAG_W-1:0]  ft;
      target = -1;
      ow     = 1'b0;
      if (it.cmd == CMD_INSERT) begin
        insert_count++;
        if (it.reminder_time == '0) begin
          queue_result(KIND_INSERT_DONE, '0, it.reminder_tag, 1'b0, 1'b1);
          return;
        end
        for (int i = 0; i < SLOTS; i++)
          if (target < 0 && due_time[i] == '0) target = i;
        if (target < 0) begin
          // full: earliest due time loses, ties to the lowest slot
          target = 0;
          for (int i = 1; i < SLOTS; i++)
            if (due_time[i] < due_time[target]) target = i;
          ow = 1'b1;
          overwrite_count++;
        end else begin
          occupied++;
        end
        due_time[target] = it.reminder_time;
        slot_tag[target] = it.reminder_tag;
        queue_result(KIND_INSERT_DONE, OUT_IDX_W'(target), it.reminder_tag, ow, 1'b1);
      end else begin
        tick_count++;
        now_w = {1'b0, it.current_time};
        win_w = (TIME_W+1)'(window);
        for (int i = 0; i < SLOTS; i++) begin
          if (due_time[i] != '0) begin
            due_w = {1'b0, due_time[i]};
            if (due_w + win_w < now_w) begin
              free_slot(i);
            end else if (due_w < now_w + win_w && due_w + win_w > now_w) begin
              ft = slot_tag[i];
              free_slot(i);
              fired_count++;
              queue_result(KIND_FIRED, OUT_IDX_W'(i), ft, 1'b0, 1'b0);
            end
          end
        end
        queue_result(KIND_SCAN_DONE, '0, '0, 1'b0, 1'b1);
      end
    endfunction

    // Compare one result beat with the oldest one owed
    function void check_result(out_item_t got);
      out_item_t want;
      result_count++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("[%0t] unexpected result beat: kind %0d slot %0d tag %h cnt %0d",
                   $realtime, got.result_kind, got.slot_index, got.fired_tag,
                   got.entry_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind || got.slot_index !== want.slot_index ||
          got.fired_tag !== want.fired_tag || got.overwrote !== want.overwrote ||
          got.entry_count !== want.entry_count || got.last !== want.last) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("[%0t] result mismatch: exp kind %0d slot %0d tag %h ow %0d cnt %0d last %0d,%s",
                   $realtime, want.result_kind, want.slot_index, want.fired_tag,
                   want.overwrote, want.entry_count, want.last, "");
        if (err_count <= MAX_SHOWN)
          $display("    got kind %0d slot %0d tag %h ow %0d cnt %0d last %0d",
                   got.result_kind, got.slot_index, got.fired_tag, got.overwrote,
                   got.entry_count, got.last);
      end
    endfunction

    function int unsigned closing_errors();
      if (pending_results.size() != 0) begin
        $display("%0d expected result beats never arrived", pending_results.size());
        err_count += pending_results.size();
      end
      return err_count;
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [WIN_W-1:0] cfg_wdata_i;
  bit               tx_idle, rx_idle;
  logic [TIME_W-1:0] sweep_now;
  int unsigned      window_settings;
  alarm_scoreboard  tracker;

  rat_in_if  in_if ();
  rat_out_if out_if ();

  reminder_alarm_table u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #2ms;
    $display("Timeout: run did not finish, %0d beats still owed",
             tracker.pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 90) return $urandom_range(4, 8);
    else return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure
  initial begin
    int unsigned hold;
    hold         = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        hold = pick_gap() - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) tracker.check_result(out_if.data);
  end

  function automatic in_item_t make_insert(logic [TIME_W-1:0] t, logic [TAG_W-1:0] tag);
    in_item_t it;
    it.cmd           = CMD_INSERT;
    it.reminder_time = t;
    it.reminder_tag  = tag;
    it.current_time  = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_tick(logic [TIME_W-1:0] now);
    in_item_t it;
    it.cmd           = CMD_TICK;
    it.reminder_time = $urandom;
    it.reminder_tag  = TAG_W'($urandom);
    it.current_time  = now;
    return it;
  endfunction

  // Drive one beat after an optional gap and wait for it to be taken
  task automatic send_beat(input in_item_t it);
    int unsigned gap;
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.note_input(it);
  endtask

  // Stop sending and let every owed result drain
  task automatic settle_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_window(w);
    window_settings++;
  endtask

  // Edge cases: zero insert, fill and overwrite, window boundaries, top of time range
  task automatic run_directed();
    send_beat(make_insert(32'd0, 16'hFFFF));
    send_beat(make_tick(32'd0));
    send_beat(make_insert(32'd100, 16'h0000));
    send_beat(make_insert(32'd200, 16'hFFFF));
    send_beat(make_insert(32'd50, 16'h1234));
    send_beat(make_insert(32'd50, 16'h5678));
    send_beat(make_insert(32'd300, 16'hABCD));
    send_beat(make_insert(32'hFFFF_FFFF, 16'h8001));
    send_beat(make_insert(32'd1000, 16'h7FFE));
    send_beat(make_insert(32'd150, 16'h00FF));
    // table full: tie on earliest time goes to the lower slot
    send_beat(make_insert(32'd500, 16'h4242));
    send_beat(make_insert(32'd60, 16'h0606));
    // clock still below the window: nothing may expire
    send_beat(make_tick(32'd10));
    // due exactly one window back neither fires nor expires
    send_beat(make_tick(32'd90));
    send_beat(make_tick(32'd125));
    send_beat(make_tick(32'd200));
    settle_idle();
    // zero window: nothing fires, due == now waits
    write_window(8'd0);
    send_beat(make_tick(32'd300));
    send_beat(make_tick(32'd301));
    send_beat(make_insert(32'd301, 16'h0F0F));
    send_beat(make_tick(32'd301));
    settle_idle();
    // widest window at the top of the time range, no wraparound
    write_window(8'd255);
    send_beat(make_tick(32'hFFFF_FFFF));
    send_beat(make_insert(32'hFFFF_FFFF, 16'hFFFF));
    send_beat(make_tick(32'hFFFF_FF00));
    send_beat(make_tick(32'hFFFF_FF01));
  endtask

  // Reminders placed around a moving clock, with some noise beats
  task automatic run_random(input int unsigned count);
    int unsigned r, w;
    sweep_now = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5000);
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      w = 32'(tracker.window);
      if (r < 45)
        send_beat(make_insert(sweep_now + $urandom_range(0, 3 * w + 20),
                              TAG_W'($urandom)));
      else if (r < 48)
        send_beat(make_insert($urandom, TAG_W'($urandom)));
      else if (r < 50)
        send_beat(make_insert(32'd0, TAG_W'($urandom)));
      else if (r < 95) begin
        sweep_now = sweep_now + $urandom_range(0, w + 8);
        send_beat(make_tick(sweep_now));
      end else
        send_beat(make_tick($urandom));
    end
  endtask

  initial begin
    logic [WIN_W-1:0] phase_window [6];
    in_if.valid     = 1'b0;
    in_if.data      = '0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    rst_ni          = 1'b0;
    tx_idle         = 1'b0;
    rx_idle         = 1'b0;
    sweep_now       = '0;
    window_settings = 1;
    tracker         = new();
    phase_window[0] = WIN_W'($urandom_range(1, 254));
    phase_window[1] = 8'd255;
    phase_window[2] = 8'd0;
    phase_window[3] = 8'd1;
    phase_window[4] = WIN_W'($urandom_range(2, 254));
    phase_window[5] = WINDOW_RESET;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // first phase runs back to back, the rest with gaps on both sides
    for (int p = 0; p < 6; p++) begin
      settle_idle();
      write_window(phase_window[p]);
      tx_idle = (p != 0);
      rx_idle = (p != 0);
      run_random(66);
    end
    settle_idle();

    $display("Run covered %0d inserts (%0d overwrites) and %0d ticks (%0d fired)",
             tracker.insert_count, tracker.overwrite_count, tracker.tick_count,
             tracker.fired_count);
    $display("  across %0d window settings, %0d result beats checked",
             window_settings, tracker.result_count);
    if (tracker.closing_errors() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
